[rtl/core/sdtq_pkg.sv]
package sdtq_pkg;

   localparam int SLOTS_DEF = 16;
   localparam int THREADS_DEF = 64;

   localparam logic [1:0] OP_INSERT  = 2'd0;
   localparam logic [1:0] OP_UNLINK  = 2'd1;
   localparam logic [1:0] OP_SCAN    = 2'd2;
   localparam logic [1:0] OP_SERVICE = 2'd3;

   localparam logic [2:0] KIND_OK       = 3'd0;
   localparam logic [2:0] KIND_LINKED   = 3'd1;
   localparam logic [2:0] KIND_SIGNAL   = 3'd2;
   localparam logic [2:0] KIND_SCAN_END = 3'd3;
   localparam logic [2:0] KIND_FIRED    = 3'd4;
   localparam logic [2:0] KIND_NONE_DUE = 3'd5;

   // datapath commands
   localparam logic [3:0] CMD_NOP       = 4'd0;
   localparam logic [3:0] CMD_LATCH     = 4'd1;  // capture request, start walk at head
   localparam logic [3:0] CMD_STEP      = 4'd2;  // advance walk cursor
   localparam logic [3:0] CMD_INS_WRITE = 4'd3;  // write entry fields
   localparam logic [3:0] CMD_INS_LINK  = 4'd4;  // link before cursor or at tail
   localparam logic [3:0] CMD_UNLINK    = 4'd5;  // unlink target; clear done when target is the request slot
   localparam logic [3:0] CMD_FIRE      = 4'd7;  // mark cursor done, set target

   typedef struct packed {
      logic [3:0] cmd;
      logic       target_cursor; // unlink uses cursor instead of request slot
   } ctl_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic       cur_valid;    // cursor is a slot and step budget left
      logic       cur_done;
      logic       cur_due;      // cursor deadline <= request time
      logic       cur_later;    // cursor deadline > request key
      logic       cur_owner_hit;
      logic       cur_signalled;
      logic       tgt_linked;
      logic       tgt_remove;
   } sts_type;

endpackage

[rtl/core/sdtq_datapath.sv]
module sdtq_datapath #(
   parameter int SLOTS = sdtq_pkg::SLOTS_DEF,
   parameter int THREADS = sdtq_pkg::THREADS_DEF,
   localparam int SW = $clog2(SLOTS),
   localparam int LW = $clog2(SLOTS + 1),
   localparam int TW = $clog2(THREADS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  sdtq_pkg::ctl_type    ctl,
   output sdtq_pkg::sts_type    sts,
   input  logic [1:0]           req_opcode,
   input  logic [3:0]           req_slot,
   input  logic [31:0]          req_time_sec,
   input  logic [19:0]          req_time_usec,
   input  logic [5:0]           req_thread,
   input  logic                 req_auto_remove,
   output logic [SW-1:0]        fired_slot,
   output logic [TW-1:0]        cur_owner,
   output logic [31:0]          cur_sec,
   output logic [19:0]          cur_usec
);

   localparam logic [LW-1:0] NONE = LW'(SLOTS);

   logic [31:0]   dl_sec [SLOTS];
   logic [19:0]   dl_usec [SLOTS];
   logic [TW-1:0] owner [SLOTS];
   logic [SLOTS-1:0] done_ff, remove_ff, linked_ff;
   logic [LW-1:0] next_ff [SLOTS];
   logic [LW-1:0] prev_ff [SLOTS];
   logic [LW-1:0] head_ff;

   logic [1:0]    op_ff;
   logic [SW-1:0] slot_ff;
   logic [51:0]   key_ff;
   logic [TW-1:0] thr_ff;
   logic          ar_ff;
   logic [LW-1:0] cur_ff, tail_ff;
   logic [LW-1:0] steps_ff;
   logic [SW-1:0] tgt_ff;

   logic [SW-1:0] cidx, tidx, uidx;
   logic [51:0]   ckey;
   logic [LW-1:0] up, un;

   assign cidx = cur_ff[SW-1:0];
   assign tidx = slot_ff;
   assign ckey = {dl_sec[cidx], dl_usec[cidx]};
   assign uidx = ctl.target_cursor ? cidx : tidx;
   assign up = prev_ff[uidx];
   assign un = next_ff[uidx];

   assign cur_owner = owner[cidx];
   assign cur_sec = dl_sec[cidx];
   assign cur_usec = dl_usec[cidx];
   assign fired_slot = tgt_ff;

   always_comb begin
      sts.opcode = op_ff;
      sts.cur_valid = (cur_ff < NONE) && (steps_ff < LW'(SLOTS));
      sts.cur_done = done_ff[cidx];
      sts.cur_due = ckey <= key_ff;
      sts.cur_later = ckey > key_ff;
      sts.cur_owner_hit = owner[cidx] == thr_ff;
      // signalled set is kept outside the datapath
      sts.cur_signalled = 1'b0;
      sts.tgt_linked = linked_ff[tidx];
      sts.tgt_remove = remove_ff[cidx];
   end

   // entry payload and request latch, no reset
   always_ff @(posedge clock) begin
      if (ctl.cmd == sdtq_pkg::CMD_INS_WRITE) begin
         dl_sec[tidx] <= key_ff[51:20];
         dl_usec[tidx] <= key_ff[19:0];
         owner[tidx] <= thr_ff;
      end
      if (ctl.cmd == sdtq_pkg::CMD_LATCH) begin
         op_ff <= req_opcode;
         slot_ff <= SW'(32'(req_slot) % SLOTS);
         key_ff <= {req_time_sec, req_time_usec};
         thr_ff <= TW'(32'(req_thread) % THREADS);
         ar_ff <= req_auto_remove;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= '0;
         remove_ff <= '0;
         linked_ff <= '0;
         head_ff <= NONE;
         cur_ff <= NONE;
         tail_ff <= NONE;
         steps_ff <= '0;
         tgt_ff <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            next_ff[i] <= NONE;
            prev_ff[i] <= NONE;
         end
      end else begin
         case (ctl.cmd)
            sdtq_pkg::CMD_LATCH: begin
               cur_ff <= head_ff;
               tail_ff <= NONE;
               steps_ff <= '0;
            end
            sdtq_pkg::CMD_STEP: begin
               tail_ff <= cur_ff;
               cur_ff <= next_ff[cidx];
               steps_ff <= steps_ff + 1'b1;
            end
            sdtq_pkg::CMD_INS_WRITE: begin
               remove_ff[tidx] <= ar_ff;
               done_ff[tidx] <= 1'b0;
            end
            sdtq_pkg::CMD_INS_LINK: begin
               linked_ff[tidx] <= 1'b1;
               if (sts.cur_valid) begin
                  // link in front of cursor
                  next_ff[tidx] <= cur_ff;
                  prev_ff[tidx] <= prev_ff[cidx];
                  if (prev_ff[cidx] < NONE) next_ff[prev_ff[cidx][SW-1:0]] <= LW'(tidx);
                  else head_ff <= LW'(tidx);
                  prev_ff[cidx] <= LW'(tidx);
               end else begin
                  next_ff[tidx] <= NONE;
                  prev_ff[tidx] <= tail_ff;
                  if (tail_ff < NONE) next_ff[tail_ff[SW-1:0]] <= LW'(tidx);
                  else head_ff <= LW'(tidx);
               end
            end
            sdtq_pkg::CMD_UNLINK: begin
               if (!ctl.target_cursor) done_ff[uidx] <= 1'b0;
               if (linked_ff[uidx]) begin
                  if (up < NONE) next_ff[up[SW-1:0]] <= un;
                  else head_ff <= un;
                  if (un < NONE) prev_ff[un[SW-1:0]] <= up;
                  next_ff[uidx] <= NONE;
                  prev_ff[uidx] <= NONE;
                  linked_ff[uidx] <= 1'b0;
               end
            end
            sdtq_pkg::CMD_FIRE: begin
               done_ff[cidx] <= 1'b1;
               tgt_ff <= cidx;
            end
            default: begin
            end
         endcase
      end
   end

endmodule

[rtl/core/sdtq_control.sv]
module sdtq_control (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sdtq_pkg::sts_type sts,
   output sdtq_pkg::ctl_type ctl,
   output logic              emit,
   output logic [2:0]        emit_kind,
   output logic              emit_last,
   output logic              emit_next,
   input  logic              out_busy
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DISP = 3'd1;
   localparam logic [2:0] S_WALK = 3'd2;  // insert search / service search
   localparam logic [2:0] S_SKIP = 3'd3;  // scan: skip done prefix
   localparam logic [2:0] S_SCAN = 3'd4;
   localparam logic [2:0] S_LINK = 3'd5;
   localparam logic [2:0] S_FIRE = 3'd6;

   logic [2:0] state_ff, state_in;

   assign req_stall = state_ff != S_IDLE;

   always_comb begin
      state_in = state_ff;
      ctl.cmd = sdtq_pkg::CMD_NOP;
      ctl.target_cursor = 1'b0;
      emit = 1'b0;
      emit_kind = sdtq_pkg::KIND_OK;
      emit_last = 1'b1;
      emit_next = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.cmd = sdtq_pkg::CMD_LATCH;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            if (!out_busy) begin
               case (sts.opcode)
                  sdtq_pkg::OP_INSERT: begin
                     if (sts.tgt_linked) begin
                        emit = 1'b1;
                        emit_kind = sdtq_pkg::KIND_LINKED;
                        state_in = S_IDLE;
                     end else begin
                        ctl.cmd = sdtq_pkg::CMD_INS_WRITE;
                        state_in = S_WALK;
                     end
                  end
                  sdtq_pkg::OP_UNLINK: begin
                     ctl.cmd = sdtq_pkg::CMD_UNLINK;
                     emit = 1'b1;
                     state_in = S_IDLE;
                  end
                  sdtq_pkg::OP_SCAN: state_in = S_SKIP;
                  default: state_in = S_WALK;
               endcase
            end
         end
         S_WALK: begin
            if (sts.opcode == sdtq_pkg::OP_INSERT) begin
               if (sts.cur_valid && !sts.cur_later) ctl.cmd = sdtq_pkg::CMD_STEP;
               else state_in = S_LINK;
            end else if (!sts.cur_valid) begin
               if (!out_busy) begin
                  emit = 1'b1;
                  emit_kind = sdtq_pkg::KIND_NONE_DUE;
                  state_in = S_IDLE;
               end
            end else if (!sts.cur_done && sts.cur_owner_hit && sts.cur_due) begin
               ctl.cmd = sdtq_pkg::CMD_FIRE;
               state_in = S_FIRE;
            end else begin
               ctl.cmd = sdtq_pkg::CMD_STEP;
            end
         end
         S_LINK: begin
            if (!out_busy) begin
               ctl.cmd = sdtq_pkg::CMD_INS_LINK;
               emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_FIRE: begin
            if (!out_busy) begin
               if (sts.tgt_remove) begin
                  ctl.cmd = sdtq_pkg::CMD_UNLINK;
                  ctl.target_cursor = 1'b1;
               end
               emit = 1'b1;
               emit_kind = sdtq_pkg::KIND_FIRED;
               state_in = S_IDLE;
            end
         end
         S_SKIP: begin
            if (sts.cur_valid && sts.cur_done) ctl.cmd = sdtq_pkg::CMD_STEP;
            else state_in = S_SCAN;
         end
         S_SCAN: begin
            if (!out_busy) begin
               if (sts.cur_valid && sts.cur_due) begin
                  ctl.cmd = sdtq_pkg::CMD_STEP;
                  if (!sts.cur_signalled) begin
                     // mark and step share the cycle: signal set happens on owner
                     emit = 1'b1;
                     emit_kind = sdtq_pkg::KIND_SIGNAL;
                     emit_last = 1'b0;
                  end
               end else begin
                  emit = 1'b1;
                  emit_kind = sdtq_pkg::KIND_SCAN_END;
                  emit_next = sts.cur_valid;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

endmodule

[rtl/core/sdtq_sigwalk.sv]
module sdtq_sigwalk #(
   parameter int THREADS = sdtq_pkg::THREADS_DEF,
   localparam int TW = $clog2(THREADS)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          clear,
   input  logic          mark,
   input  logic [TW-1:0] owner,
   output logic          seen
);
   // per-scan signalled-thread set
   logic [THREADS-1:0] seen_ff;
   assign seen = seen_ff[owner];
   always_ff @(posedge clock) begin
      if (reset || clear) seen_ff <= '0;
      else if (mark) seen_ff[owner] <= 1'b1;
   end
endmodule

[rtl/core/sorted_deadline_timer_queue_unit.sv]
// Sorted deadline timer queue.
// Request channel (req_*): one word per operation, accepted when req_valid
// is high and req_stall low. Opcodes: insert, unlink, scan, service.
// Response channel (rsp_*): one word per result, taken when rsp_valid is high
// and rsp_stall low; rsp_last marks the final word of an operation.
// One operation at a time. Unlink and a refused insert load their word
// from the dispatch state; insert and service walk the linked list one
// entry per cycle, visiting at most SLOTS entries before the word is loaded.
// A scan gives one signal word per cycle for each due entry whose owner
// was not yet signalled, while the response side does not stall, then the
// scan-end word. The walk through the link table sets the rate.
// Reset clears all link, mark and control state at once; deadlines and
// owners stay undefined until an insert writes them.
// A stall on the response side holds the single output register; the
// controller waits in place until that register frees, and no request is
// taken until the last word of the current one has been loaded.
module sorted_deadline_timer_queue_unit #(
   parameter int SLOTS = sdtq_pkg::SLOTS_DEF,
   parameter int THREADS = sdtq_pkg::THREADS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [3:0]  req_slot,
   input  logic [31:0] req_time_sec,
   input  logic [19:0] req_time_usec,
   input  logic [5:0]  req_thread,
   input  logic        req_auto_remove,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [3:0]  rsp_result_slot,
   output logic [5:0]  rsp_signal_thread,
   output logic [31:0] rsp_next_sec,
   output logic [19:0] rsp_next_usec,
   output logic        rsp_next_valid,
   output logic        rsp_last
);

   localparam int SW = $clog2(SLOTS);
   localparam int TW = $clog2(THREADS);

   sdtq_pkg::ctl_type ctl, dp_ctl;
   sdtq_pkg::sts_type sts, dp_sts;
   logic          emit, emit_last, emit_next, out_busy, seen;
   logic [2:0]    emit_kind;
   logic [SW-1:0] fired_slot;
   logic [TW-1:0] cur_owner;
   logic [31:0]   cur_sec;
   logic [19:0]   cur_usec;

   // output register is busy while it holds a word not yet taken
   assign out_busy = rsp_valid && rsp_stall;

   sdtq_control u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .sts, .ctl,
      .emit, .emit_kind, .emit_last, .emit_next, .out_busy
   );

   // signalled set lives in its own unit; take that status bit from it
   always_comb begin
      dp_ctl = ctl;
      sts = dp_sts;
      sts.cur_signalled = seen;
   end

   sdtq_sigwalk #(.THREADS(THREADS)) u_sig (
      .clock, .reset,
      .clear(ctl.cmd == sdtq_pkg::CMD_LATCH),
      .mark(emit && emit_kind == sdtq_pkg::KIND_SIGNAL),
      .owner(cur_owner), .seen
   );

   sdtq_datapath #(.SLOTS(SLOTS), .THREADS(THREADS)) u_dp (
      .clock, .reset, .ctl(dp_ctl), .sts(dp_sts),
      .req_opcode, .req_slot, .req_time_sec, .req_time_usec, .req_thread,
      .req_auto_remove, .fired_slot, .cur_owner, .cur_sec, .cur_usec
   );

   // response register: load on emit, drop when taken
   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else if (emit) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_kind <= emit_kind;
         rsp_last <= emit_last;
         rsp_result_slot <= (emit_kind == sdtq_pkg::KIND_FIRED) ? 4'(fired_slot) : 4'd0;
         rsp_signal_thread <= (emit_kind == sdtq_pkg::KIND_SIGNAL) ? 6'(cur_owner) : 6'd0;
         rsp_next_sec <= emit_next ? cur_sec : 32'd0;
         rsp_next_usec <= emit_next ? cur_usec : 20'd0;
         rsp_next_valid <= emit_next;
      end
   end

endmodule

[bench/sdtq_checker.sv]
module sdtq_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [3:0]  req_slot,
   input  logic [31:0] req_time_sec,
   input  logic [19:0] req_time_usec,
   input  logic [5:0]  req_thread,
   input  logic        req_auto_remove,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_kind,
   input  logic [3:0]  rsp_result_slot,
   input  logic [5:0]  rsp_signal_thread,
   input  logic [31:0] rsp_next_sec,
   input  logic [19:0] rsp_next_usec,
   input  logic        rsp_next_valid,
   input  logic        rsp_last,
   output int          fail_count,
   output int          words_pending,
   output logic        req_taken,
   output logic        rsp_taken
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NS = 16;

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  slot;
      logic [5:0]  thread;
      logic [31:0] sec;
      logic [19:0] usec;
      logic        nvalid;
      logic        last;
   } word_type;

   logic [31:0] dl_sec [NS];
   logic [19:0] dl_usec [NS];
   logic [5:0]  owner [NS];
   logic        done_q [NS];
   logic        autorm [NS];
   logic        linked [NS];
   int          nxt [NS];
   int          prv [NS];
   int          head;
   word_type    timer_words [$];

   assign words_pending = timer_words.size();
   assign req_taken = req_valid && !req_stall;
   assign rsp_taken = rsp_valid && !rsp_stall;

   function automatic logic [51:0] key_at(int s);
      return {dl_sec[s], dl_usec[s]};
   endfunction

   function automatic void push_word(logic [2:0] k, logic [3:0] s, logic [5:0] t,
                                     logic [31:0] sc, logic [19:0] us, logic v);
      word_type w;
      w = '{kind: k, slot: s, thread: t, sec: sc, usec: us, nvalid: v, last: 1'b0};
      timer_words.push_back(w);
   endfunction

   function automatic void drop_link(int s);
      int p, n;
      p = prv[s];
      n = nxt[s];
      if (p < NS) nxt[p] = n; else head = n;
      if (n < NS) prv[n] = p;
      nxt[s] = NS;
      prv[s] = NS;
      linked[s] = 0;
   endfunction

   function automatic void link_sorted(int s);
      int e, tail, steps, p;
      e = head;
      tail = NS;
      for (steps = 0; e < NS && steps < NS; steps++) begin
         if (key_at(e) > key_at(s)) begin
            p = prv[e];
            nxt[s] = e;
            prv[s] = p;
            if (p < NS) nxt[p] = s; else head = s;
            prv[e] = s;
            linked[s] = 1;
            return;
         end
         tail = e;
         e = nxt[e];
      end
      nxt[s] = NS;
      prv[s] = tail;
      if (tail < NS) nxt[tail] = s; else head = s;
      linked[s] = 1;
   endfunction

   function automatic void predict_timer_op(logic [1:0] op, logic [3:0] s, logic [31:0] sc,
                                            logic [19:0] us, logic [5:0] th, logic ar);
      logic [51:0] now;
      logic [63:0] signalled;
      int e, steps, found;
      word_type w;
      now = {sc, us};
      if (op == sdtq_pkg::OP_INSERT) begin
         if (linked[s]) push_word(sdtq_pkg::KIND_LINKED, '0, '0, '0, '0, 1'b0);
         else begin
            dl_sec[s] = sc;
            dl_usec[s] = us;
            owner[s] = th;
            autorm[s] = ar;
            done_q[s] = 0;
            link_sorted(s);
            push_word(sdtq_pkg::KIND_OK, '0, '0, '0, '0, 1'b0);
         end
      end else if (op == sdtq_pkg::OP_UNLINK) begin
         if (linked[s]) drop_link(s);
         done_q[s] = 0;
         push_word(sdtq_pkg::KIND_OK, '0, '0, '0, '0, 1'b0);
      end else if (op == sdtq_pkg::OP_SCAN) begin
         signalled = '0;
         e = head;
         steps = 0;
         while (e < NS && steps < NS && done_q[e]) begin
            e = nxt[e];
            steps++;
         end
         while (e < NS && steps < NS) begin
            if (key_at(e) > now) break;
            if (!signalled[owner[e]]) begin
               signalled[owner[e]] = 1'b1;
               push_word(sdtq_pkg::KIND_SIGNAL, '0, owner[e], '0, '0, 1'b0);
            end
            e = nxt[e];
            steps++;
         end
         if (e < NS && steps < NS)
            push_word(sdtq_pkg::KIND_SCAN_END, '0, '0, dl_sec[e], dl_usec[e], 1'b1);
         else push_word(sdtq_pkg::KIND_SCAN_END, '0, '0, '0, '0, 1'b0);
      end else begin
         found = NS;
         e = head;
         for (steps = 0; e < NS && steps < NS; steps++) begin
            if (!done_q[e] && owner[e] == th && key_at(e) <= now) begin
               found = e;
               break;
            end
            e = nxt[e];
         end
         if (found < NS) begin
            done_q[found] = 1;
            if (autorm[found]) drop_link(found);
            push_word(sdtq_pkg::KIND_FIRED, found[3:0], '0, '0, '0, 1'b0);
         end else push_word(sdtq_pkg::KIND_NONE_DUE, '0, '0, '0, '0, 1'b0);
      end
      w = timer_words.pop_back();
      w.last = 1'b1;
      timer_words.push_back(w);
   endfunction

   always @(posedge clock) begin
      word_type got, want;
      if (reset) begin
         for (int i = 0; i < NS; i++) begin
            done_q[i] = 0;
            autorm[i] = 0;
            linked[i] = 0;
            nxt[i] = NS;
            prv[i] = NS;
         end
         head = NS;
         fail_count <= 0;
         timer_words.delete();
      end else begin
         // check the word first: a result can never belong to the request taken this edge
         if (rsp_taken) begin
            got = '{kind: rsp_kind, slot: rsp_result_slot, thread: rsp_signal_thread,
                    sec: rsp_next_sec, usec: rsp_next_usec, nvalid: rsp_next_valid,
                    last: rsp_last};
            if (timer_words.size() == 0) begin
               $display("%0t: unexpected word, actual %p", $realtime, got);
               fail_count <= fail_count + 1;
            end else begin
               want = timer_words.pop_front();
               if (got != want) begin
                  $display("%0t: mismatch, expected %p, actual %p", $realtime, want, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_taken)
            predict_timer_op(req_opcode, req_slot, req_time_sec, req_time_usec,
                             req_thread, req_auto_remove);
      end
   end
endmodule

[bench/tb.sv]
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_opcode;
   logic [3:0]  req_slot;
   logic [31:0] req_time_sec;
   logic [19:0] req_time_usec;
   logic [5:0]  req_thread;
   logic        req_auto_remove;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_kind;
   logic [3:0]  rsp_result_slot;
   logic [5:0]  rsp_signal_thread;
   logic [31:0] rsp_next_sec;
   logic [19:0] rsp_next_usec;
   logic        rsp_next_valid;
   logic        rsp_last;
   int          fail_count;
   int          words_pending;
   logic        req_taken;
   logic        rsp_taken;
   logic        words_done;
   int          quiet_cycles;

   // Limit on cycles with no word moving on either channel. A long receiver
   // hold-off plus slow walks stays well below it.
   localparam int QUIET_LIMIT = 5000;

   sorted_deadline_timer_queue_unit dut (.*);

   sdtq_checker chk (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Watchdog: count cycles in which nothing moves on either channel.
   always @(posedge clock) begin
      if (reset || req_taken || rsp_taken) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Receiver: random stall per word, one long hold-off early in the random part.
   initial begin
      int gap;
      rsp_stall = 1'b1;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!words_done) begin
            gap = $urandom_range(0, 6);
            if ($urandom_range(0, 3) == 0) gap = 0;
            rsp_stall <= (gap != 0);
            repeat (gap) @(negedge clock);
            rsp_stall <= 1'b0;
            @(posedge clock);
            while (!rsp_taken) @(posedge clock);
            @(negedge clock);
         end else begin
            // hold off long while the sender keeps offering requests
            rsp_stall <= 1'b1;
            repeat (300) @(negedge clock);
            rsp_stall <= 1'b0;
            words_done = 1'b0;
            @(negedge clock);
         end
      end
   end

   // Offer one request and wait until it is taken; inputs move at falling edges.
   task automatic send_op(logic [1:0] op, logic [3:0] s, logic [31:0] sc, logic [19:0] us,
                          logic [5:0] th, logic ar);
      int gap;
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_slot <= s;
      req_time_sec <= sc;
      req_time_usec <= us;
      req_thread <= th;
      req_auto_remove <= ar;
      @(posedge clock);
      while (!req_taken) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drop_request();
      req_valid <= 1'b0;
   endtask

   initial begin
      logic [31:0] base;
      logic [31:0] sc;
      logic [19:0] us;
      logic [3:0]  s;
      int          r;
      words_done = 1'b0;
      req_valid = 1'b0;
      req_opcode = sdtq_pkg::OP_INSERT;
      req_slot = '0;
      req_time_sec = '0;
      req_time_usec = '0;
      req_thread = '0;
      req_auto_remove = 1'b0;
      reset = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty scan and service, extremes of the fields, refused insert,
      // equal deadlines, over-range microseconds, auto-remove, done entries.
      send_op(sdtq_pkg::OP_SCAN, 4'd0, 32'd0, 20'd0, 6'd0, 1'b0);
      send_op(sdtq_pkg::OP_SERVICE, 4'd0, 32'hFFFF_FFFF, 20'hFFFFF, 6'd63, 1'b0);
      send_op(sdtq_pkg::OP_UNLINK, 4'd15, 32'd0, 20'd0, 6'd0, 1'b0);
      send_op(sdtq_pkg::OP_INSERT, 4'd0, 32'd0, 20'd0, 6'd0, 1'b1);
      send_op(sdtq_pkg::OP_INSERT, 4'd15, 32'hFFFF_FFFF, 20'hFFFFF, 6'd63, 1'b0);
      send_op(sdtq_pkg::OP_INSERT, 4'd15, 32'd5, 20'd5, 6'd1, 1'b0);
      send_op(sdtq_pkg::OP_INSERT, 4'd7, 32'd10, 20'd999999, 6'd5, 1'b0);
      send_op(sdtq_pkg::OP_INSERT, 4'd8, 32'd10, 20'd999999, 6'd5, 1'b1);
      send_op(sdtq_pkg::OP_INSERT, 4'd9, 32'd10, 20'd1000000, 6'd6, 1'b0);
      send_op(sdtq_pkg::OP_INSERT, 4'd10, 32'd10, 20'd0, 6'd42, 1'b0);
      send_op(sdtq_pkg::OP_SCAN, 4'd3, 32'd10, 20'd999999, 6'd0, 1'b0);
      send_op(sdtq_pkg::OP_SERVICE, 4'd0, 32'd10, 20'd999999, 6'd0, 1'b0);
      send_op(sdtq_pkg::OP_SERVICE, 4'd0, 32'd10, 20'd999999, 6'd5, 1'b0);
      send_op(sdtq_pkg::OP_SERVICE, 4'd0, 32'd10, 20'd999999, 6'd5, 1'b0);
      send_op(sdtq_pkg::OP_SERVICE, 4'd0, 32'd10, 20'd999999, 6'd5, 1'b0);
      send_op(sdtq_pkg::OP_SCAN, 4'd0, 32'd11, 20'd0, 6'd0, 1'b0);
      send_op(sdtq_pkg::OP_SCAN, 4'd0, 32'hFFFF_FFFF, 20'hFFFFF, 6'd0, 1'b0);
      send_op(sdtq_pkg::OP_INSERT, 4'd8, 32'd3, 20'd0, 6'd5, 1'b0);
      send_op(sdtq_pkg::OP_UNLINK, 4'd7, 32'd0, 20'd0, 6'd0, 1'b0);
      send_op(sdtq_pkg::OP_UNLINK, 4'd7, 32'd0, 20'd0, 6'd0, 1'b0);
      send_op(sdtq_pkg::OP_SERVICE, 4'd0, 32'd9, 20'd0, 6'd6, 1'b0);

      // Random: inserts the largest share, with deadlines near a moving clock, so scans and
      // service calls find due work; a few extreme values and stray unlinks.
      base = 32'd100;
      for (int i = 0; i < 300; i++) begin
         if (i == 40) words_done = 1'b1;  // start the long receiver hold-off
         r = $urandom_range(0, 99);
         s = 4'($urandom_range(0, 15));
         if ($urandom_range(0, 9) == 0) begin
            sc = $urandom;
            us = 20'($urandom);
         end else begin
            sc = base + $urandom_range(0, 6);
            us = ($urandom_range(0, 7) == 0) ? 20'($urandom) : 20'($urandom_range(0, 3));
         end
         if (r < 40)
            send_op(sdtq_pkg::OP_INSERT, s, sc, us,
                    6'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3)),
                    1'($urandom));
         else if (r < 55)
            send_op(sdtq_pkg::OP_UNLINK, s, $urandom, 20'($urandom), 6'($urandom),
                    1'($urandom));
         else if (r < 75)
            send_op(sdtq_pkg::OP_SCAN, s, sc, us, 6'($urandom), 1'($urandom));
         else
            send_op(sdtq_pkg::OP_SERVICE, s, sc, us,
                    6'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3)),
                    1'($urandom));
         if ($urandom_range(0, 4) == 0) base = base + $urandom_range(1, 3);
      end
      drop_request();

      // Drain, then allow the block's walk time before the verdict.
      while (words_pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0 && words_pending == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule
